@@ hdl/scbp_pkg.sv @@
// Shared types and constants for the scope command byte parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scbp_pkg;

  // Block constants
  localparam logic [15:0] MAX_SAMPLES     = 16'd1024;
  localparam logic [15:0] DEFAULT_SAMPLES = 16'd512;
  localparam logic [31:0] DEFAULT_DIVIDER = 32'd96;
  localparam logic [1:0]  RESET_CHANNEL   = 2'd0;

  // Action codes reported with each result
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_START    = 3'd1;
  localparam logic [2:0] ACT_STOP     = 3'd2;
  localparam logic [2:0] ACT_RATE     = 3'd3;
  localparam logic [2:0] ACT_CHANNEL  = 3'd4;
  localparam logic [2:0] ACT_SAMPLES  = 3'd5;
  localparam logic [2:0] ACT_PING     = 3'd6;
  localparam logic [2:0] ACT_NOEFFECT = 3'd7;

  // Payload lengths in bytes
  localparam logic [2:0] LEN_RATE    = 3'd4;
  localparam logic [2:0] LEN_CHANNEL = 3'd1;
  localparam logic [2:0] LEN_SAMPLES = 3'd2;
  localparam logic [2:0] LEN_NONE    = 3'd0;

  localparam logic [1:0] CHANNEL_MASK = 2'b11;

  // Configuration register indexes
  localparam logic [2:0] CFG_START   = 3'd0;
  localparam logic [2:0] CFG_STOP    = 3'd1;
  localparam logic [2:0] CFG_RATE    = 3'd2;
  localparam logic [2:0] CFG_CHANNEL = 3'd3;
  localparam logic [2:0] CFG_SAMPLES = 3'd4;
  localparam logic [2:0] CFG_PING    = 3'd5;
  localparam logic [2:0] CFG_DIV_LO  = 3'd6;
  localparam logic [2:0] CFG_DIV_HI  = 3'd7;

  typedef struct packed {
    logic [7:0]  start_opcode;
    logic [7:0]  stop_opcode;
    logic [7:0]  rate_opcode;
    logic [7:0]  channel_opcode;
    logic [7:0]  samples_opcode;
    logic [7:0]  ping_opcode;
    logic [31:0] divider_floor;
    logic [31:0] divider_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  opcode_hold;
    logic [31:0] payload_shift;
    logic [2:0]  bytes_received;
    logic [2:0]  bytes_expected;
    logic        streaming_flag;
    logic [31:0] divider_value;
    logic [1:0]  channel_value;
    logic [15:0] frame_samples;
  } state_t;

endpackage

@@ hdl/scbp_exec.sv @@
// Per-byte next-state and action logic of the command parser.
// Purely combinational; uses scbp_pkg types and codes.
`timescale 1ns / 1ps

module scbp_exec import scbp_pkg::*; (
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  input  state_t     st,
  output state_t     st_next,
  output logic [2:0] act
);

  // first match wins when opcode registers collide
  function automatic logic [2:0] decode_kind(input logic [7:0] op, input cfg_t c);
    logic [2:0] k;
    k = ACT_NOEFFECT;
    priority if (op == c.start_opcode)   k = ACT_START;
    else if (op == c.stop_opcode)        k = ACT_STOP;
    else if (op == c.rate_opcode)        k = ACT_RATE;
    else if (op == c.channel_opcode)     k = ACT_CHANNEL;
    else if (op == c.samples_opcode)     k = ACT_SAMPLES;
    else if (op == c.ping_opcode)        k = ACT_PING;
    else                                 k = ACT_NOEFFECT;
    return k;
  endfunction

  function automatic logic [2:0] payload_len(input logic [2:0] k);
    logic [2:0] n;
    unique case (k)
      ACT_RATE:    n = LEN_RATE;
      ACT_CHANNEL: n = LEN_CHANNEL;
      ACT_SAMPLES: n = LEN_SAMPLES;
      default:     n = LEN_NONE;
    endcase
    return n;
  endfunction

  always_comb begin
    state_t      s;
    logic [1:0]  pos;
    logic [2:0]  kind;
    logic [31:0] div_v;
    logic [15:0] smp_v;

    s   = st;
    act = ACT_NONE;
    pos = st.bytes_received[1:0] - 2'd1;

    if (st.bytes_received == 3'd0) begin
      s.opcode_hold    = rx_byte;
      s.payload_shift  = 32'd0;
      s.bytes_received = 3'd1;
      s.bytes_expected = 3'd1 + payload_len(decode_kind(rx_byte, cfg));
    end else begin
      // little-endian assembly
      s.payload_shift  = st.payload_shift | ({24'd0, rx_byte} << {pos, 3'b000});
      s.bytes_received = st.bytes_received + 3'd1;
    end

    div_v = s.payload_shift;
    if (div_v < cfg.divider_floor) div_v = cfg.divider_floor;
    if (div_v > cfg.divider_ceiling) div_v = cfg.divider_ceiling;

    smp_v = s.payload_shift[15:0];
    if (smp_v == 16'd0) smp_v = 16'd1;
    else if (smp_v > MAX_SAMPLES) smp_v = MAX_SAMPLES;

    kind = decode_kind(s.opcode_hold, cfg);

    if (s.bytes_received >= s.bytes_expected) begin
      unique case (kind)
        ACT_START: begin
          if (s.streaming_flag) begin
            act = ACT_NOEFFECT;
          end else begin
            s.streaming_flag = 1'b1;
            act = ACT_START;
          end
        end
        ACT_STOP: begin
          if (!s.streaming_flag) begin
            act = ACT_NOEFFECT;
          end else begin
            s.streaming_flag = 1'b0;
            act = ACT_STOP;
          end
        end
        ACT_RATE: begin
          s.divider_value = div_v;
          act = ACT_RATE;
        end
        ACT_CHANNEL: begin
          s.channel_value = s.payload_shift[1:0] & CHANNEL_MASK;
          act = ACT_CHANNEL;
        end
        ACT_SAMPLES: begin
          s.frame_samples = smp_v;
          act = ACT_SAMPLES;
        end
        ACT_PING: begin
          act = ACT_PING;
        end
        default: begin
          act = ACT_NOEFFECT;
        end
      endcase
      s.bytes_received = 3'd0;
      s.bytes_expected = 3'd0;
    end

    st_next = s;
  end

endmodule

@@ hdl/scope_command_byte_parser_core.sv @@
// Top level of the scope command byte parser: configuration registers,
// parser state, result register. Uses scbp_pkg and scbp_exec.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one host byte per
//   transaction. The first byte of a command is its opcode; set-rate takes 4
//   payload bytes, set-channel 1, set-samples 2, all others none.
//   Output channel (out_valid/out_ready) returns exactly one result per byte:
//   the action taken (none while a command is incomplete) and the current
//   streaming flag, divider, channel and samples per frame.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   opcode registers and the divider bounds; it is always ready and should be
//   used only while the parser is idle.
// Timing and throughput: the result of a byte is registered and appears in the
//   cycle after it is accepted; one byte per cycle is sustained while out_ready
//   is high, set by the single result register that the state update feeds.
// Stall: while a result waits with out_ready low, in_ready drops; a waiting
//   result is freed and replaced in the same cycle when out_ready is high.
// Reset: synchronous, active high; clears the parser state, loads the default
//   divider, channel and samples and the default opcodes, empties the output.
`timescale 1ns / 1ps

module scope_command_byte_parser_core import scbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // host bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic        streaming_on,
  output logic [31:0] clock_divider,
  output logic [1:0]  input_channel,
  output logic [15:0] samples_per_frame,
  output logic        mid_command,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t       cfg;
  state_t     st;
  state_t     st_next;
  logic [2:0] act_next;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  scbp_exec u_exec (
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .act     (act_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_opcode    <= 8'd1;
      cfg.stop_opcode     <= 8'd2;
      cfg.rate_opcode     <= 8'd3;
      cfg.channel_opcode  <= 8'd4;
      cfg.samples_opcode  <= 8'd5;
      cfg.ping_opcode     <= 8'd6;
      cfg.divider_floor   <= 32'd96;
      cfg.divider_ceiling <= 32'd65535;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START:   cfg.start_opcode    <= cfg_data[7:0];
        CFG_STOP:    cfg.stop_opcode     <= cfg_data[7:0];
        CFG_RATE:    cfg.rate_opcode     <= cfg_data[7:0];
        CFG_CHANNEL: cfg.channel_opcode  <= cfg_data[7:0];
        CFG_SAMPLES: cfg.samples_opcode  <= cfg_data[7:0];
        CFG_PING:    cfg.ping_opcode     <= cfg_data[7:0];
        CFG_DIV_LO:  cfg.divider_floor   <= cfg_data;
        CFG_DIV_HI:  cfg.divider_ceiling <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.opcode_hold    <= 8'd0;
      st.payload_shift  <= 32'd0;
      st.bytes_received <= 3'd0;
      st.bytes_expected <= 3'd0;
      st.streaming_flag <= 1'b0;
      st.divider_value  <= DEFAULT_DIVIDER;
      st.channel_value  <= RESET_CHANNEL;
      st.frame_samples  <= DEFAULT_SAMPLES;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      action            <= act_next;
      streaming_on      <= st_next.streaming_flag;
      clock_divider     <= st_next.divider_value;
      input_channel     <= st_next.channel_value;
      samples_per_frame <= st_next.frame_samples;
      mid_command       <= (st_next.bytes_received != 3'd0);
    end
  end

endmodule

@@ hdl/scbp_checker.sv @@
// Port-level checks for the scope command byte parser, bound to the top level.
// Uses scbp_pkg codes and limits.
`timescale 1ns / 1ps

module scbp_checker import scbp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  action,
  input logic        streaming_on,
  input logic [15:0] samples_per_frame,
  input logic        mid_command
);

  // no action is reported exactly while payload is still awaited
  a_mid_none: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((action == ACT_NONE) == mid_command))
    else $error("mid_command and action disagree");

  a_samples_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (samples_per_frame != 16'd0 && samples_per_frame <= MAX_SAMPLES))
    else $error("samples per frame outside clamp range");

  a_stream_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_START || action == ACT_STOP)
      |-> (streaming_on == (action == ACT_START)))
    else $error("streaming flag does not follow start/stop");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action))
    else $error("stalled result changed");

endmodule

bind scope_command_byte_parser_core scbp_checker u_scbp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .action            (action),
  .streaming_on      (streaming_on),
  .samples_per_frame (samples_per_frame),
  .mid_command       (mid_command)
);
